// ===== sv/lrpe_pkg.sv =====
// Shared types, register codes and helper functions for the LCD refresh engine.
`default_nettype none

package lrpe_pkg;

  localparam int unsigned MODE_GFX    = 0;
  localparam int unsigned MODE_DISP   = 3;
  localparam int unsigned MODE_BLINK  = 4;
  localparam int unsigned MODE_CURSOR = 5;
  localparam int unsigned MODE_FAST   = 6;

  localparam logic [5:0] BLINK_FAST = 6'd16;
  localparam logic [5:0] BLINK_SLOW = 6'd32;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_PITCH  = 3'd1,
    REG_BPL    = 3'd2,
    REG_LPH    = 3'd3,
    REG_CROWS  = 3'd4,
    REG_START  = 3'd5,
    REG_CURSOR = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_OFF   = 2'd0,
    OP_START = 2'd1,
    OP_PIX   = 2'd2
  } op_t;

  typedef struct packed {
    logic [6:0]  mode;
    logic [7:0]  pitch;
    logic [6:0]  bpl;
    logic [6:0]  lph;
    logic [7:0]  crows;
    logic [15:0] start;
    logic [15:0] cursor;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [6:0] col_pre;
    logic [3:0] ras_pre;
    logic [6:0] row_pre;
    logic       half_pre;
    logic [6:0] col_post;
    logic [3:0] ras_post;
    logic [6:0] row_post;
    logic       half_post;
    logic       cur_vis;
    logic       last;
  } seq_item_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [6:0]  col_pre;
    logic [3:0]  ras_pre;
    logic [11:0] line_pre;
    logic [11:0] line_post;
    logic [6:0]  col_post;
    logic [3:0]  ras_post;
    logic        cur_vis;
    logic        last;
  } line_item_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [3:0]  ras_pre;
    logic [9:0]  screen_x;
    logic [11:0] screen_y;
    logic [15:0] fetch_addr;
    logic [3:0]  fetch_row;
    logic [15:0] pre_addr;
    logic        cur_vis;
    logic        last;
  } pix_item_t;

  typedef struct packed {
    logic        fetch_valid;
    logic [15:0] fetch_address;
    logic [3:0]  fetch_row;
    logic        pixels_valid;
    logic [7:0]  pixel_bits;
    logic [3:0]  pixel_count;
    logic [9:0]  screen_x;
    logic [11:0] screen_y;
    logic        frame_done;
  } res_t;

  function automatic logic is_gfx(cfg_t c);
    return c.mode[MODE_GFX];
  endfunction

  function automatic logic [4:0] vpitch(cfg_t c);
    return c.mode[MODE_GFX] ? 5'd1 : ({1'b0, c.pitch[7:4]} + 5'd1);
  endfunction

  function automatic logic [3:0] hpitch(cfg_t c);
    return {1'b0, c.pitch[2:0]} + 4'd1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lrpe_cfg.sv =====
// APB-style register file holding the display configuration.
`default_nettype none

module lrpe_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output lrpe_pkg::cfg_t cfg
);
  import lrpe_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:   cfg_r.mode   <= pwdata[6:0];
        REG_PITCH:  cfg_r.pitch  <= pwdata[7:0];
        REG_BPL:    cfg_r.bpl    <= pwdata[6:0];
        REG_LPH:    cfg_r.lph    <= pwdata[6:0];
        REG_CROWS:  cfg_r.crows  <= pwdata[7:0];
        REG_START:  cfg_r.start  <= pwdata[15:0];
        REG_CURSOR: cfg_r.cursor <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = {25'd0, cfg_r.mode};
      REG_PITCH:  prdata = {24'd0, cfg_r.pitch};
      REG_BPL:    prdata = {25'd0, cfg_r.bpl};
      REG_LPH:    prdata = {25'd0, cfg_r.lph};
      REG_CROWS:  prdata = {24'd0, cfg_r.crows};
      REG_START:  prdata = {16'd0, cfg_r.start};
      REG_CURSOR: prdata = {16'd0, cfg_r.cursor};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/lrpe_seq.sv =====
// Frame sequencer: scan counters, cursor blink and the first pipeline register.
`default_nettype none

module lrpe_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lrpe_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [7:0]           in_video_data,
  output logic                 s1_valid,
  input  logic                 s1_ready,
  output lrpe_pkg::seq_item_t  s1_item,
  output logic                 frame_active
);
  import lrpe_pkg::*;

  logic [6:0] col_r, col_nxt;
  logic [3:0] ras_r, ras_nxt;
  logic [6:0] row_r, row_nxt;
  logic       half_r, half_nxt;
  logic       vis_r, vis_nxt;
  logic [5:0] blink_r, blink_nxt;
  logic       active_r, active_nxt;
  logic       s1_valid_r;
  seq_item_t  s1_item_r, s1_item_nxt;

  logic [6:0] adv_col;
  logic [3:0] adv_ras;
  logic [6:0] adv_row;
  logic       adv_half;
  logic       adv_end;
  logic       accept;
  logic       push;
  logic [5:0] period;

  assign in_ready     = !s1_valid_r || s1_ready;
  assign accept       = in_valid && in_ready;
  assign s1_valid     = s1_valid_r;
  assign s1_item      = s1_item_r;
  assign frame_active = active_r;
  assign period       = cfg.mode[MODE_FAST] ? BLINK_FAST : BLINK_SLOW;

  always_comb begin
    adv_col  = 7'd0;
    adv_ras  = ras_r;
    adv_row  = row_r;
    adv_half = half_r;
    adv_end  = 1'b0;
    if (col_r < cfg.bpl) begin
      adv_col = col_r + 7'd1;
    end else if (!half_r) begin
      adv_half = 1'b1;
    end else if (!is_gfx(cfg) && (ras_r < cfg.pitch[7:4])) begin
      adv_half = 1'b0;
      adv_ras  = ras_r + 4'd1;
    end else if (row_r < cfg.lph) begin
      adv_half = 1'b0;
      adv_ras  = 4'd0;
      adv_row  = row_r + 7'd1;
    end else begin
      adv_half = 1'b0;
      adv_ras  = 4'd0;
      adv_row  = 7'd0;
      adv_end  = 1'b1;
    end
  end

  always_comb begin
    col_nxt     = col_r;
    ras_nxt     = ras_r;
    row_nxt     = row_r;
    half_nxt    = half_r;
    vis_nxt     = vis_r;
    blink_nxt   = blink_r;
    active_nxt  = active_r;
    push        = 1'b0;
    s1_item_nxt = s1_item_r;
    if (accept) begin
      if (!in_kind) begin
        push        = 1'b1;
        s1_item_nxt = '0;
        if (!cfg.mode[MODE_DISP]) begin
          s1_item_nxt.op = OP_OFF;
          active_nxt     = 1'b0;
        end else begin
          s1_item_nxt.op = OP_START;
          col_nxt        = 7'd0;
          ras_nxt        = 4'd0;
          row_nxt        = 7'd0;
          half_nxt       = 1'b0;
          active_nxt     = 1'b1;
          if (is_gfx(cfg)) begin
            vis_nxt   = 1'b0;
            blink_nxt = 6'd0;
          end else if (!cfg.mode[MODE_CURSOR]) begin
            vis_nxt = 1'b0;
          end else if (!cfg.mode[MODE_BLINK]) begin
            vis_nxt = 1'b1;
          end else if (blink_r == period) begin
            vis_nxt   = !vis_r;
            blink_nxt = 6'd0;
          end else begin
            blink_nxt = blink_r + 6'd1;
          end
        end
      end else if (active_r) begin
        push                  = 1'b1;
        s1_item_nxt.op        = OP_PIX;
        s1_item_nxt.data      = in_video_data;
        s1_item_nxt.col_pre   = col_r;
        s1_item_nxt.ras_pre   = ras_r;
        s1_item_nxt.row_pre   = row_r;
        s1_item_nxt.half_pre  = half_r;
        s1_item_nxt.col_post  = adv_col;
        s1_item_nxt.ras_post  = adv_ras;
        s1_item_nxt.row_post  = adv_row;
        s1_item_nxt.half_post = adv_half;
        s1_item_nxt.cur_vis   = vis_r;
        s1_item_nxt.last      = adv_end;
        col_nxt               = adv_col;
        ras_nxt               = adv_ras;
        row_nxt               = adv_row;
        half_nxt              = adv_half;
        if (adv_end) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= 7'd0;
      ras_r      <= 4'd0;
      row_r      <= 7'd0;
      half_r     <= 1'b0;
      vis_r      <= 1'b0;
      blink_r    <= 6'd0;
      active_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      ras_r    <= ras_nxt;
      row_r    <= row_nxt;
      half_r   <= half_nxt;
      vis_r    <= vis_nxt;
      blink_r  <= blink_nxt;
      active_r <= active_nxt;
      if (in_ready) begin
        s1_valid_r <= push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s1_item_r <= s1_item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lrpe_addr.sv =====
// Two address stages: line index, then fetch address and screen position.
`default_nettype none

module lrpe_addr (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lrpe_pkg::cfg_t       cfg,
  input  logic                 s1_valid,
  output logic                 s1_ready,
  input  lrpe_pkg::seq_item_t  s1_item,
  output logic                 s3_valid,
  input  logic                 s3_ready,
  output lrpe_pkg::pix_item_t  s3_item
);
  import lrpe_pkg::*;

  logic       s2_valid_r;
  line_item_t s2_item_r, s2_item_nxt;
  logic       s3_valid_r;
  pix_item_t  s3_item_r, s3_item_nxt;
  logic [15:0] cur_addr_r;
  logic        s2_load;
  logic        s3_load;
  logic        addr_upd;
  logic [7:0]  hn;
  logic [19:0] line_bytes;
  logic [10:0] sx;

  function automatic logic [11:0] line_index(cfg_t c, logic [6:0] row, logic half,
                                             logic [3:0] ras);
    logic [7:0]  nx;
    logic [7:0]  full_row;
    logic [12:0] prod;
    logic [3:0]  ra;
    nx       = {1'b0, c.lph} + 8'd1;
    full_row = {1'b0, row} + (half ? nx : 8'd0);
    ra       = is_gfx(c) ? 4'd0 : ras;
    prod     = full_row * vpitch(c);
    return prod[11:0] + {8'd0, ra};
  endfunction

  assign s3_load  = !s3_valid_r || s3_ready;
  assign s2_load  = !s2_valid_r || s3_load;
  assign s1_ready = s2_load;
  assign s3_valid = s3_valid_r;
  assign s3_item  = s3_item_r;

  always_comb begin
    s2_item_nxt.op        = s1_item.op;
    s2_item_nxt.data      = s1_item.data;
    s2_item_nxt.col_pre   = s1_item.col_pre;
    s2_item_nxt.ras_pre   = s1_item.ras_pre;
    s2_item_nxt.line_pre  = line_index(cfg, s1_item.row_pre, s1_item.half_pre,
                                       s1_item.ras_pre);
    s2_item_nxt.line_post = line_index(cfg, s1_item.row_post, s1_item.half_post,
                                       s1_item.ras_post);
    s2_item_nxt.col_post  = s1_item.col_post;
    s2_item_nxt.ras_post  = s1_item.ras_post;
    s2_item_nxt.cur_vis   = s1_item.cur_vis;
    s2_item_nxt.last      = s1_item.last;
  end

  assign hn         = {1'b0, cfg.bpl} + 8'd1;
  assign line_bytes = s2_item_r.line_post * hn;
  assign sx         = s2_item_r.col_pre * hpitch(cfg);
  assign addr_upd   = (s2_item_r.op == OP_START) ||
                      ((s2_item_r.op == OP_PIX) && !s2_item_r.last);

  always_comb begin
    s3_item_nxt.op         = s2_item_r.op;
    s3_item_nxt.data       = s2_item_r.data;
    s3_item_nxt.ras_pre    = s2_item_r.ras_pre;
    s3_item_nxt.screen_x   = sx[9:0];
    s3_item_nxt.screen_y   = s2_item_r.line_pre;
    s3_item_nxt.fetch_addr = cfg.start + line_bytes[15:0] + {9'd0, s2_item_r.col_post};
    s3_item_nxt.fetch_row  = is_gfx(cfg) ? 4'd0 : s2_item_r.ras_post;
    s3_item_nxt.pre_addr   = cur_addr_r;
    s3_item_nxt.cur_vis    = s2_item_r.cur_vis;
    s3_item_nxt.last       = s2_item_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      cur_addr_r <= 16'd0;
    end else begin
      if (s2_load) begin
        s2_valid_r <= s1_valid;
      end
      if (s3_load) begin
        s3_valid_r <= s2_valid_r;
        if (s2_valid_r && addr_upd) begin
          cur_addr_r <= s3_item_nxt.fetch_addr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      s2_item_r <= s2_item_nxt;
    end
    if (s3_load && s2_valid_r) begin
      s3_item_r <= s3_item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lrpe_pix.sv =====
// Cursor inversion and the result register.
`default_nettype none

module lrpe_pix (
  input  logic                clk,
  input  logic                rst_n,
  input  lrpe_pkg::cfg_t      cfg,
  input  logic                s3_valid,
  output logic                s3_ready,
  input  lrpe_pkg::pix_item_t s3_item,
  output logic                res_valid,
  input  logic                res_ready,
  output lrpe_pkg::res_t      res
);
  import lrpe_pkg::*;

  logic       res_valid_r;
  res_t       res_r, res_nxt;
  logic [3:0] ra;
  logic       hit;

  assign s3_ready  = !res_valid_r || res_ready;
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign ra        = is_gfx(cfg) ? 4'd0 : s3_item.ras_pre;
  assign hit       = s3_item.cur_vis && (s3_item.pre_addr == cfg.cursor) &&
                     (ra >= cfg.crows[7:4]) && (ra <= cfg.crows[3:0]);

  always_comb begin
    res_nxt = '0;
    case (s3_item.op)
      OP_START: begin
        res_nxt.fetch_valid   = 1'b1;
        res_nxt.fetch_address = s3_item.fetch_addr;
        res_nxt.fetch_row     = 4'd0;
      end
      OP_PIX: begin
        res_nxt.pixels_valid = 1'b1;
        res_nxt.pixel_bits   = s3_item.data ^ {8{hit}};
        res_nxt.pixel_count  = hpitch(cfg);
        res_nxt.screen_x     = s3_item.screen_x;
        res_nxt.screen_y     = s3_item.screen_y;
        if (s3_item.last) begin
          res_nxt.frame_done = 1'b1;
        end else begin
          res_nxt.fetch_valid   = 1'b1;
          res_nxt.fetch_address = s3_item.fetch_addr;
          res_nxt.fetch_row     = s3_item.fetch_row;
        end
      end
      default: begin
        res_nxt.frame_done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (s3_ready) begin
      res_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lcd_refresh_address_and_pixel_engine_core.sv =====
// Top level of the dual-half dot-matrix LCD refresh and pixel engine.
// The input channel takes two kinds of transaction: a frame start (kind 0), and a
// video byte (kind 1) returned by display memory for the last requested fetch.
// Every frame start, and every video byte taken while a frame is running, gives
// exactly one result transaction: the next fetch request, the pixel group with its
// screen position and cursor applied; frame_done on the last byte or display off.
// Video bytes that arrive with no frame running are taken and dropped.
// The configuration registers sit on an APB-style port, one 32-bit word each.
// Each transaction passes the sequencer register, the line index stage, the fetch
// address stage and the result register before its result is presented. One
// transaction is accepted every cycle unless the pipeline is stalled; the scan
// counters and blink state update in the accept cycle, so a new byte can follow
// at once.
// When the receiver stalls, the four stages fill up one by one and in_ready
// drops only once all of them hold a transaction. Reset clears the registers,
// the counters, the cursor blink state and all stage valid flags.
`default_nettype none

module lcd_refresh_address_and_pixel_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_video_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_fetch_valid,
  output logic [15:0] out_fetch_address,
  output logic [3:0]  out_fetch_row,
  output logic        out_pixels_valid,
  output logic [7:0]  out_pixel_bits,
  output logic [3:0]  out_pixel_count,
  output logic [9:0]  out_screen_x,
  output logic [11:0] out_screen_y,
  output logic        out_frame_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lrpe_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic       s1_ready;
  seq_item_t  s1_item;
  logic       s3_valid;
  logic       s3_ready;
  pix_item_t  s3_item;
  res_t       res;
  logic       frame_active;

  lrpe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lrpe_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_video_data (in_video_data),
    .s1_valid      (s1_valid),
    .s1_ready      (s1_ready),
    .s1_item       (s1_item),
    .frame_active  (frame_active)
  );

  lrpe_addr u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_item  (s1_item),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3_item  (s3_item)
  );

  lrpe_pix u_pix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s3_valid  (s3_valid),
    .s3_ready  (s3_ready),
    .s3_item   (s3_item),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_fetch_valid   = res.fetch_valid;
  assign out_fetch_address = res.fetch_address;
  assign out_fetch_row     = res.fetch_row;
  assign out_pixels_valid  = res.pixels_valid;
  assign out_pixel_bits    = res.pixel_bits;
  assign out_pixel_count   = res.pixel_count;
  assign out_screen_x      = res.screen_x;
  assign out_screen_y      = res.screen_y;
  assign out_frame_done    = res.frame_done;

  // Input backpressure only comes from a full pipeline behind a stalled result.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  a_pixel_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixels_valid) |-> (out_pixel_count == hpitch(cfg)))
    else $error("pixel count does not match the horizontal pitch");

  a_display_off_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_kind && !cfg.mode[MODE_DISP]) |=> !frame_active)
    else $error("frame still running after a display-off frame start");

endmodule

`default_nettype wire
